// ===== sv/zwtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Zone worst thermal margin package
// Widths and output limits shared by the block and checker, and the block's stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package zwtm_pkg;

  localparam int TempW = 19;
  localparam int GainW = 16;
  localparam int DiffW = 21;  // target + offset - reading
  localparam int ProdW = GainW + DiffW;
  localparam int QW    = ProdW - 7;  // rounded product after the divide by 256
  localparam int SumW  = 32;
  localparam int OutW  = 21;

  localparam logic signed [OutW-1:0] OutMax = 21'sd1000000;
  localparam logic signed [OutW-1:0] OutMin = -21'sd1000000;

  // Record that leaves the multiply stage.
  typedef struct packed {
    logic                    take;  // the item contributes a value
    logic                    err;   // the item flags a zone error
    logic                    last;  // the item closes the zone
    logic signed [TempW-1:0] base;  // reading or set point
    logic signed [ProdW-1:0] prod;  // scaled difference, zero when unused
  } calc_t;

endpackage

`default_nettype wire

// ===== sv/zone_worst_thermal_margin.sv =====
// ----------------------------------------------------------------------------
// Zone worst thermal margin
// Tracks the smallest calibrated margin over the sensors of one zone.
// ----------------------------------------------------------------------------
// One sensor record is taken per item and one item can enter every cycle. An
// item passes an input register, a multiply stage and an accumulate stage; a
// result is written to the output register when the item that closes the
// zone leaves the accumulate stage. The throughput is one item per cycle;
// the only stall comes from a zone result that still waits in the output
// register when the next zone end reaches the accumulate stage.
`default_nettype none

module zone_worst_thermal_margin
  import zwtm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic signed [TempW-1:0] reading_i,
  input  wire logic                    reading_ok_i,
  input  wire logic                    service_absent_i,
  input  wire logic                    is_margin_i,
  input  wire logic signed [TempW-1:0] spec_temp_i,
  input  wire logic                    spec_ok_i,
  input  wire logic signed [GainW-1:0] gain_i,
  input  wire logic signed [TempW-1:0] target_temp_i,
  input  wire logic                    target_given_i,
  input  wire logic signed [TempW-1:0] target_offset_i,
  input  wire logic signed [TempW-1:0] set_point_i,
  input  wire logic                    last_sensor_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic signed [OutW-1:0]  zone_margin_o,
  output      logic                    margin_valid_o,
  output      logic                    error_seen_o
);

  localparam logic signed [SumW-1:0] SatHi = SumW'(OutMax);
  localparam logic signed [SumW-1:0] SatLo = SumW'(OutMin);

  // Configuration.
  logic mode_q;

  // Input register.
  logic                    v1_q;
  logic signed [TempW-1:0] reading_q, spec_q, target_q, offset_q, setp_q;
  logic signed [GainW-1:0] gain_q;
  logic                    rd_ok_q, svc_abs_q, is_marg_q, spec_ok_q, tgt_given_q, last_q;

  // Multiply stage.
  logic  v2_q;
  calc_t s2_q, s2_d;

  // Zone state.
  logic signed [OutW-1:0] min_q;
  logic                   present_q, zerr_q;

  // Output register.
  logic                   out_valid_q;
  logic signed [OutW-1:0] out_margin_q;
  logic                   out_mvalid_q, out_err_q;

  logic out_free, fire2, ready2, fire1, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire2      = v2_q && (!s2_q.last || out_free);
  assign ready2     = !v2_q || fire2;
  assign fire1      = v1_q && ready2;
  assign in_ready_o = !v1_q || fire1;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------- multiply stage logic ----------------
  logic signed [DiffW-1:0] diff;
  logic signed [TempW-1:0] tgt;

  always_comb begin
    tgt  = tgt_given_q ? target_q : spec_q;
    diff = DiffW'(tgt) + DiffW'(offset_q) - DiffW'(reading_q);

    s2_d      = '0;
    s2_d.last = last_q;
    if (!rd_ok_q) begin
      s2_d.err = !svc_abs_q;
    end else if (is_marg_q) begin
      s2_d.take = 1'b1;
      s2_d.base = reading_q;
    end else if (!spec_ok_q) begin
      s2_d.err = 1'b1;
    end else begin
      s2_d.take = 1'b1;
      s2_d.base = setp_q;
      if (gain_q != '0) begin
        s2_d.prod = ProdW'(gain_q) * ProdW'(diff);
      end
    end
  end

  // ---------------- accumulate stage logic ----------------
  logic signed [ProdW:0]   rnd_sum;
  logic signed [QW-1:0]    quot;
  logic signed [SumW-1:0]  value;
  logic signed [OutW-1:0]  sat_val;
  logic signed [OutW-1:0]  min_nx;
  logic                    present_nx, zerr_nx, res_valid;

  always_comb begin
    // Round half away from zero: add 128 for positive, 127 for negative.
    rnd_sum = (ProdW+1)'($signed(s2_q.prod))
              + (s2_q.prod[ProdW-1] ? (ProdW+1)'(127) : (ProdW+1)'(128));
    quot    = rnd_sum[ProdW:8];
    value   = SumW'($signed(s2_q.base)) + SumW'(quot);
    if (value > SatHi) begin
      sat_val = OutMax;
    end else if (value < SatLo) begin
      sat_val = OutMin;
    end else begin
      sat_val = value[OutW-1:0];
    end

    min_nx     = min_q;
    present_nx = present_q;
    if (s2_q.take && (!present_q || sat_val < min_q)) begin
      min_nx     = sat_val;
      present_nx = 1'b1;
    end
    zerr_nx   = zerr_q || s2_q.err;
    res_valid = present_nx && !(mode_q && zerr_nx);
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      min_q       <= '0;
      present_q   <= 1'b0;
      zerr_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= fire1;
      end
      if (fire2) begin
        if (s2_q.last) begin
          min_q     <= '0;
          present_q <= 1'b0;
          zerr_q    <= 1'b0;
        end else begin
          min_q     <= min_nx;
          present_q <= present_nx;
          zerr_q    <= zerr_nx;
        end
      end
      if (fire2 && s2_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      reading_q   <= reading_i;
      rd_ok_q     <= reading_ok_i;
      svc_abs_q   <= service_absent_i;
      is_marg_q   <= is_margin_i;
      spec_q      <= spec_temp_i;
      spec_ok_q   <= spec_ok_i;
      gain_q      <= gain_i;
      target_q    <= target_temp_i;
      tgt_given_q <= target_given_i;
      offset_q    <= target_offset_i;
      setp_q      <= set_point_i;
      last_q      <= last_sensor_i;
    end
    if (fire1) begin
      s2_q <= s2_d;
    end
    if (fire2 && s2_q.last) begin
      out_margin_q <= res_valid ? min_nx : '0;
      out_mvalid_q <= res_valid;
      out_err_q    <= zerr_nx;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign zone_margin_o  = out_margin_q;
  assign margin_valid_o = out_mvalid_q;
  assign error_seen_o   = out_err_q;

endmodule

`default_nettype wire

// ===== sv/zwtm_checker.sv =====
// ----------------------------------------------------------------------------
// Zone worst thermal margin checker
// Port-level properties of the block, bound into the block.
// ----------------------------------------------------------------------------
`default_nettype none

module zwtm_checker
  import zwtm_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    cfg_we_i,
  input wire logic                    cfg_wdata_i,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic signed [TempW-1:0] reading_i,
  input wire logic                    reading_ok_i,
  input wire logic                    service_absent_i,
  input wire logic                    is_margin_i,
  input wire logic signed [TempW-1:0] spec_temp_i,
  input wire logic                    spec_ok_i,
  input wire logic signed [GainW-1:0] gain_i,
  input wire logic signed [TempW-1:0] target_temp_i,
  input wire logic                    target_given_i,
  input wire logic signed [TempW-1:0] target_offset_i,
  input wire logic signed [TempW-1:0] set_point_i,
  input wire logic                    last_sensor_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic signed [OutW-1:0]  zone_margin_o,
  input wire logic                    margin_valid_o,
  input wire logic                    error_seen_o
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(zone_margin_o)
      && $stable(margin_valid_o) && $stable(error_seen_o))
    else $error("result changed while stalled");

  // An invalid zone result reads as zero.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !margin_valid_o |-> zone_margin_o == '0)
    else $error("invalid result not zero");

  // The result stays within the saturation limits.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> zone_margin_o <= OutMax && zone_margin_o >= OutMin)
    else $error("result out of range");

  // The input side only backs up behind a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind zone_worst_thermal_margin zwtm_checker u_zwtm_checker (.*);

`default_nettype wire

// ===== test/tb_zone_worst_thermal_margin.sv =====
// ----------------------------------------------------------------------------
// Zone worst thermal margin testbench
// Streams sensor records through the block and checks every zone result
// against an in-bench model of the minimum tracking, with a directed table
// first and random zones under several flow-control and register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_zone_worst_thermal_margin
  import zwtm_pkg::*;
();

  localparam int PipeLat   = 3;
  localparam int HoldLen   = 300;
  localparam int WatchdogT = 4 * 400000;
  localparam longint SatHi = 1000000;
  localparam longint SatLo = -1000000;

  typedef struct {
    logic signed [TempW-1:0] reading;
    logic                    reading_ok;
    logic                    service_absent;
    logic                    is_margin;
    logic signed [TempW-1:0] spec_temp;
    logic                    spec_ok;
    logic signed [GainW-1:0] gain;
    logic signed [TempW-1:0] target_temp;
    logic                    target_given;
    logic signed [TempW-1:0] target_offset;
    logic signed [TempW-1:0] set_point;
    logic                    last_sensor;
  } sensor_t;

  typedef struct {
    logic signed [OutW-1:0] margin;
    logic                   valid;
    logic                   err;
  } zone_res_t;

  typedef struct {
    sensor_t   item;
    bit        typed;
    zone_res_t res;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic                    cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [TempW-1:0] reading_i;
  logic                    reading_ok_i;
  logic                    service_absent_i;
  logic                    is_margin_i;
  logic signed [TempW-1:0] spec_temp_i;
  logic                    spec_ok_i;
  logic signed [GainW-1:0] gain_i;
  logic signed [TempW-1:0] target_temp_i;
  logic                    target_given_i;
  logic signed [TempW-1:0] target_offset_i;
  logic signed [TempW-1:0] set_point_i;
  logic                    last_sensor_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [OutW-1:0]  zone_margin_o;
  logic                    margin_valid_o;
  logic                    error_seen_o;

  zone_worst_thermal_margin dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .reading_i       (reading_i),
    .reading_ok_i    (reading_ok_i),
    .service_absent_i(service_absent_i),
    .is_margin_i     (is_margin_i),
    .spec_temp_i     (spec_temp_i),
    .spec_ok_i       (spec_ok_i),
    .gain_i          (gain_i),
    .target_temp_i   (target_temp_i),
    .target_given_i  (target_given_i),
    .target_offset_i (target_offset_i),
    .set_point_i     (set_point_i),
    .last_sensor_i   (last_sensor_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .zone_margin_o   (zone_margin_o),
    .margin_valid_o  (margin_valid_o),
    .error_seen_o    (error_seen_o)
  );

  // Model state of the zone being folded and of the register.
  longint    worst_margin;
  bit        worst_seen;
  bit        zone_fault;
  bit        fail_mode;

  zone_res_t zone_results_q[$];
  dir_row_t  dir_rows[$];
  int        fail_count;
  int        n_items;
  int        n_zones;
  int        send_idle_pct;
  int        stall_pct;
  bit        hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(WatchdogT);
    $display("zone_worst_thermal_margin verification failed");
    $finish;
  end

  // Folds one record into the zone minimum; returns 1 when the record closes
  // the zone, with the zone result in res.
  function automatic bit fold_sensor(input sensor_t s, output zone_res_t res);
    longint v;
    longint tgt;
    longint prod;
    longint mag;
    longint q;
    bit     take;
    take = 1'b0;
    v    = 0;
    res  = '{margin: '0, valid: 1'b0, err: 1'b0};
    if (!s.reading_ok) begin
      if (!s.service_absent) zone_fault = 1'b1;
    end else if (s.is_margin) begin
      take = 1'b1;
      v    = longint'(s.reading);
    end else if (!s.spec_ok) begin
      zone_fault = 1'b1;
    end else if (s.gain == 0) begin
      take = 1'b1;
      v    = longint'(s.set_point);
    end else begin
      tgt  = s.target_given ? longint'(s.target_temp) : longint'(s.spec_temp);
      prod = longint'(s.gain) * (tgt + longint'(s.target_offset) - longint'(s.reading));
      // Divide by 256, rounding half away from zero.
      mag  = (prod < 0) ? -prod : prod;
      q    = (mag + 128) >>> 8;
      if (prod < 0) q = -q;
      take = 1'b1;
      v    = longint'(s.set_point) + q;
    end
    if (take) begin
      if (v > SatHi) v = SatHi;
      if (v < SatLo) v = SatLo;
      if (!worst_seen || v < worst_margin) begin
        worst_margin = v;
        worst_seen   = 1'b1;
      end
    end
    if (!s.last_sensor) return 1'b0;
    res.valid  = worst_seen && !(fail_mode && zone_fault);
    res.margin = res.valid ? OutW'(worst_margin) : '0;
    res.err    = zone_fault;
    worst_margin = 0;
    worst_seen   = 1'b0;
    zone_fault   = 1'b0;
    return 1'b1;
  endfunction

  function automatic sensor_t mk_item(int rd, bit rok, bit sabs, bit marg, int spec,
                                      bit sok, int g, int tgt, bit tg, int off,
                                      int sp, bit last);
    sensor_t s;
    s.reading        = TempW'(rd);
    s.reading_ok     = rok;
    s.service_absent = sabs;
    s.is_margin      = marg;
    s.spec_temp      = TempW'(spec);
    s.spec_ok        = sok;
    s.gain           = GainW'(g);
    s.target_temp    = TempW'(tgt);
    s.target_given   = tg;
    s.target_offset  = TempW'(off);
    s.set_point      = TempW'(sp);
    s.last_sensor    = last;
    return s;
  endfunction

  function automatic void add_row(sensor_t s, bit typed, int m, bit v, bit e);
    dir_row_t r;
    r.item       = s;
    r.typed      = typed;
    r.res.margin = OutW'(m);
    r.res.valid  = v;
    r.res.err    = e;
    dir_rows.push_back(r);
  endfunction

  function automatic int rand_temp();
    case ($urandom_range(9))
      0: return 200000;
      1: return -200000;
      2: return int'($urandom_range(2000)) - 1000;
      default: return int'($urandom_range(400000)) - 200000;
    endcase
  endfunction

  function automatic int rand_gain();
    case ($urandom_range(9))
      0: return 0;
      1: return 32767;
      2: return -32768;
      3, 4, 5: return int'($urandom_range(768)) - 384;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // A noisy record has its flags, the zone end among them, fully random.
  function automatic sensor_t rand_sensor(bit noisy);
    sensor_t s;
    s.reading        = TempW'(rand_temp());
    s.reading_ok     = noisy ? 1'($urandom_range(1)) : ($urandom_range(19) != 0);
    s.service_absent = 1'($urandom_range(1));
    s.is_margin      = noisy ? 1'($urandom_range(1)) : ($urandom_range(3) == 0);
    s.spec_temp      = TempW'(rand_temp());
    s.spec_ok        = noisy ? 1'($urandom_range(1)) : ($urandom_range(24) != 0);
    s.gain           = GainW'(rand_gain());
    s.target_temp    = TempW'(rand_temp());
    s.target_given   = 1'($urandom_range(1));
    s.target_offset  = TempW'($urandom_range(1) ? rand_temp()
                                                : int'($urandom_range(20000)) - 10000);
    s.set_point      = TempW'(rand_temp());
    s.last_sensor    = noisy ? 1'($urandom_range(1)) : 1'b0;
    return s;
  endfunction

  // Offers one record after a random idle gap and folds it into the model once
  // it is accepted. A typed row replaces the model's zone result.
  task automatic offer_record(input sensor_t s, input bit typed, input zone_res_t typed_res);
    int        gap;
    zone_res_t res;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    reading_i        <= s.reading;
    reading_ok_i     <= s.reading_ok;
    service_absent_i <= s.service_absent;
    is_margin_i      <= s.is_margin;
    spec_temp_i      <= s.spec_temp;
    spec_ok_i        <= s.spec_ok;
    gain_i           <= s.gain;
    target_temp_i    <= s.target_temp;
    target_given_i   <= s.target_given;
    target_offset_i  <= s.target_offset;
    set_point_i      <= s.set_point;
    last_sensor_i    <= s.last_sensor;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_items++;
    if (fold_sensor(s, res)) begin
      n_zones++;
      zone_results_q.push_back(typed ? typed_res : res);
    end
  endtask

  // Stops offering, waits for every zone result, then lets the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (zone_results_q.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 2) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    fail_mode = v;
  endtask

  task automatic run_phase(input bit mode, input int sidle, input int rstall,
                           input int count, input bit pressure);
    int        sent;
    int        zlen;
    sensor_t   s;
    zone_res_t none;
    none = '{margin: '0, valid: 1'b0, err: 1'b0};
    drain();
    write_mode(mode);
    send_idle_pct = sidle;
    stall_pct     = rstall;
    // One-sensor zones while the receiver holds off, so results pile up.
    if (pressure) hold_req = 1'b1;
    sent = 0;
    while (sent < count) begin
      if (pressure) zlen = 1;
      else if ($urandom_range(9) == 0) zlen = $urandom_range(16, 1);
      else zlen = $urandom_range(5, 1);
      for (int i = 0; i < zlen; i++) begin
        s = rand_sensor($urandom_range(9) == 0);
        if (i == zlen - 1) s.last_sensor = 1'b1;
        offer_record(s, 1'b0, none);
        sent++;
      end
    end
    // Close any zone left open by a noisy record.
    s = rand_sensor(1'b0);
    s.last_sensor = 1'b1;
    offer_record(s, 1'b0, none);
  endtask

  // Receiver: random stalls, or one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldLen) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    zone_res_t exp_res;
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (zone_results_q.size() == 0) begin
        $error("zone result with no expectation: margin %0d valid %0d error %0d",
               zone_margin_o, margin_valid_o, error_seen_o);
        fail_count++;
      end else begin
        exp_res = zone_results_q.pop_front();
        if (zone_margin_o !== exp_res.margin) begin
          $error("zone_margin: expected %0d, got %0d", exp_res.margin, zone_margin_o);
          fail_count++;
        end
        if (margin_valid_o !== exp_res.valid) begin
          $error("margin_valid: expected %0d, got %0d", exp_res.valid, margin_valid_o);
          fail_count++;
        end
        if (error_seen_o !== exp_res.err) begin
          $error("error_seen: expected %0d, got %0d", exp_res.err, error_seen_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count    = 0;
    n_items       = 0;
    n_zones       = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    worst_margin  = 0;
    worst_seen    = 1'b0;
    zone_fault    = 1'b0;
    fail_mode     = 1'b0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= 1'b0;
    in_valid_i       <= 1'b0;
    reading_i        <= '0;
    reading_ok_i     <= 1'b0;
    service_absent_i <= 1'b0;
    is_margin_i      <= 1'b0;
    spec_temp_i      <= '0;
    spec_ok_i        <= 1'b0;
    gain_i           <= '0;
    target_temp_i    <= '0;
    target_given_i   <= 1'b0;
    target_offset_i  <= '0;
    set_point_i      <= '0;
    last_sensor_i    <= 1'b0;

    // Margin readings at both extremes.
    add_row(mk_item(200000, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1), 1, 200000, 1, 0);
    add_row(mk_item(-200000, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1), 1, -200000, 1, 0);
    // Missing reading: error unless the service is absent.
    add_row(mk_item(0, 0, 0, 0, 0, 1, 256, 0, 0, 0, 0, 1), 1, 0, 0, 1);
    add_row(mk_item(0, 0, 1, 0, 0, 1, 256, 0, 0, 0, 0, 1), 1, 0, 0, 0);
    // Missing spec flags an error even with zero gain.
    add_row(mk_item(1000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 5000, 1), 1, 0, 0, 1);
    // Zero gain gives the set point and ignores the target fields.
    add_row(mk_item(1000, 1, 0, 0, 90000, 1, 0, 0, 0, 0, 200000, 1), 1, 200000, 1, 0);
    add_row(mk_item(-200000, 1, 1, 0, 200000, 1, 0, -200000, 1, 200000, -200000, 1),
            1, -200000, 1, 0);
    // A present reading ignores service_absent; a margin ignores spec and gain.
    add_row(mk_item(1234, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1), 1, 1234, 1, 0);
    add_row(mk_item(5000, 1, 0, 1, -200000, 0, 32767, 200000, 1, -200000, 200000, 1),
            1, 5000, 1, 0);
    // Three-sensor zone with an error on the closing sensor.
    add_row(mk_item(40000, 1, 0, 0, 100000, 1, 256, 0, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(mk_item(70000, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(mk_item(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0);
    // Saturation at both ends of the output range.
    add_row(mk_item(-200000, 1, 0, 0, 200000, 1, 32767, 0, 0, 200000, 200000, 1),
            1, 1000000, 1, 0);
    add_row(mk_item(-200000, 1, 0, 0, 200000, 1, -32768, 0, 0, 200000, -200000, 1),
            1, -1000000, 1, 0);
    // Rounding ties and a value just under a tie.
    add_row(mk_item(0, 1, 0, 0, 128, 1, 1, 0, 0, 0, 0, 1), 0, 0, 0, 0);
    add_row(mk_item(0, 1, 0, 0, 128, 1, -1, 0, 0, 0, 0, 1), 0, 0, 0, 0);
    add_row(mk_item(0, 1, 0, 0, 127, 1, 1, 0, 0, 0, 0, 1), 0, 0, 0, 0);
    // Given target with extreme offset.
    add_row(mk_item(200000, 1, 0, 0, 0, 1, 256, -200000, 1, -200000, 0, 1), 0, 0, 0, 0);
    // The minimum holds against a later, larger value.
    add_row(mk_item(-50, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(mk_item(50, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0);
    // Negative gain, then a skipped record closes the zone.
    add_row(mk_item(100, 1, 0, 0, 200000, 1, -384, -150000, 1, -60000, -150000, 0),
            0, 0, 0, 0);
    add_row(mk_item(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b0);
    foreach (dir_rows[i]) offer_record(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    run_phase(1'b0, 0, 0, 250, 1'b0);
    run_phase(1'b1, 61, 0, 250, 1'b0);
    run_phase(1'b0, 0, 61, 250, 1'b0);
    run_phase(1'b1, 9, 9, 250, 1'b0);
    run_phase(1'b1, 0, 0, 150, 1'b1);
    run_phase(1'b0, 61, 61, 150, 1'b0);

    drain();
    repeat (4 * PipeLat) @(posedge clk_i);
    if (zone_results_q.size() != 0) begin
      $error("%0d zone results never arrived", zone_results_q.size());
      fail_count++;
    end
    $display("Sent %0d sensor records closing %0d zones, single failure mode off and on,",
             n_items, n_zones);
    $display("with sender gaps, receiver stalls, a long output hold-off and drains.");
    if (fail_count == 0) begin
      $display("zone_worst_thermal_margin verification clean");
    end else begin
      $display("zone_worst_thermal_margin verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== zone_worst_thermal_margin.f =====
sv/zwtm_pkg.sv
sv/zone_worst_thermal_margin.sv
sv/zwtm_checker.sv
test/tb_zone_worst_thermal_margin.sv
